### hw/rtl/wf23_pkg.sv
// Shared types, register codes and constants for the Winograd F(2,3) output requantizer.
`timescale 1ns / 1ps

package wf23_pkg;

  localparam int NUM_LANES = 4;
  localparam int ADDR_W = 5;
  localparam int SUM_SHIFT = 2;
  localparam int PROD_SHIFT = 31;

  localparam logic [1:0] LAST_ROW = 2'd3;

  localparam logic [30:0] MULT_RESET = 31'h4000_0000;
  localparam logic [4:0] SHIFT_RESET = 5'd0;
  localparam logic [7:0] ZP_RESET = 8'd0;
  localparam logic [7:0] LOW_RESET = 8'd0;
  localparam logic [7:0] HIGH_RESET = 8'd255;

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    REG_MULT = 3'd0,
    REG_SHIFT = 3'd1,
    REG_ZP = 3'd2,
    REG_LOW = 3'd3,
    REG_HIGH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] tile_col0;
    logic signed [31:0] tile_col1;
    logic signed [31:0] tile_col2;
    logic signed [31:0] tile_col3;
    logic signed [31:0] chan_bias;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_r0c0;
    logic [7:0] out_r0c1;
    logic [7:0] out_r1c0;
    logic [7:0] out_r1c1;
  } out_item_t;

  typedef struct packed {
    logic [30:0] multiplier;
    logic [4:0] shift;
    logic [7:0] zero_point;
    logic [7:0] clamp_low;
    logic [7:0] clamp_high;
  } cfg_t;

endpackage

### hw/rtl/winograd_f23_output_requant_unit.sv
// Top level: configuration registers, row accumulator, four requant lanes and output register.
// A finished tile passes the accumulator capture, lane and output registers.
// Throughput: one row per cycle; one result per four rows, set by the accumulator.
// A stalled output holds the lanes and the fourth row; rows one to three still transfer.
// Reset clears the row counter, partial sums, valid flags and restores register defaults.
`timescale 1ns / 1ps

module winograd_f23_output_requant_unit import wf23_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic adv;
  logic accept;
  logic s0_valid;
  word_t s0_sum [NUM_LANES];
  word_t s0_bias;
  logic [3:0] vpipe;
  logic [7:0] lane_q [NUM_LANES];
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign adv = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.multiplier <= MULT_RESET;
      cfg.shift <= SHIFT_RESET;
      cfg.zero_point <= ZP_RESET;
      cfg.clamp_low <= LOW_RESET;
      cfg.clamp_high <= HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MULT: cfg.multiplier <= pwdata[30:0];
        REG_SHIFT: cfg.shift <= pwdata[4:0];
        REG_ZP: cfg.zero_point <= pwdata[7:0];
        REG_LOW: cfg.clamp_low <= pwdata[7:0];
        REG_HIGH: cfg.clamp_high <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MULT: prdata = {1'b0, cfg.multiplier};
      REG_SHIFT: prdata = {27'b0, cfg.shift};
      REG_ZP: prdata = {24'b0, cfg.zero_point};
      REG_LOW: prdata = {24'b0, cfg.clamp_low};
      REG_HIGH: prdata = {24'b0, cfg.clamp_high};
      default: prdata = '0;
    endcase
  end

  wf23_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .item     (in_item),
    .accept   (accept),
    .adv      (adv),
    .ready    (in_ready),
    .s0_valid (s0_valid),
    .s0_sum   (s0_sum),
    .s0_bias  (s0_bias)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    wf23_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .sum  (s0_sum[g]),
      .bias (s0_bias),
      .cfg  (cfg),
      .q    (lane_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vpipe <= {vpipe[2:0], s0_valid};
      out_valid <= vpipe[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.out_r0c0 <= lane_q[0];
      out_item.out_r0c1 <= lane_q[1];
      out_item.out_r1c0 <= lane_q[2];
      out_item.out_r1c1 <= lane_q[3];
    end
  end

endmodule

### hw/rtl/wf23_accum.sv
// Row accumulator that applies the F(2,3) transform and captures finished tiles.
`timescale 1ns / 1ps

module wf23_accum import wf23_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  logic     accept,
  input  logic     adv,
  output logic     ready,
  output logic     s0_valid,
  output word_t    s0_sum [NUM_LANES],
  output word_t    s0_bias
);

  logic [1:0] row;
  word_t ps [NUM_LANES];
  word_t ps_next [NUM_LANES];
  word_t col_a;
  word_t col_b;
  logic last;

  assign col_a = item.tile_col0 + item.tile_col1 + item.tile_col2;
  assign col_b = item.tile_col1 - item.tile_col2 - item.tile_col3;
  assign last = (row == LAST_ROW);
  assign ready = !last || adv;

  always_comb begin
    ps_next = ps;
    case (row)
      2'd0: begin
        ps_next[0] = ps[0] + col_a;
        ps_next[1] = ps[1] + col_b;
      end
      2'd1: begin
        ps_next[0] = ps[0] + col_a;
        ps_next[1] = ps[1] + col_b;
        ps_next[2] = ps[2] + col_a;
        ps_next[3] = ps[3] + col_b;
      end
      2'd2: begin
        ps_next[0] = ps[0] + col_a;
        ps_next[1] = ps[1] + col_b;
        ps_next[2] = ps[2] - col_a;
        ps_next[3] = ps[3] - col_b;
      end
      2'd3: begin
        ps_next[2] = ps[2] - col_a;
        ps_next[3] = ps[3] - col_b;
      end
      default: begin
        ps_next = ps;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      ps <= '{default: '0};
      s0_valid <= 1'b0;
    end else begin
      if (accept) begin
        row <= row + 2'd1;
        if (last) begin
          ps <= '{default: '0};
        end else begin
          ps <= ps_next;
        end
      end
      if (adv) begin
        s0_valid <= accept && last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      s0_sum <= ps_next;
      s0_bias <= item.chan_bias;
    end
  end

endmodule

### hw/rtl/wf23_lane.sv
// One requantization lane: bias, doubling high multiply, rounding shift and clamps.
`timescale 1ns / 1ps

module wf23_lane import wf23_pkg::*; (
  input  logic       clk,
  input  logic       adv,
  input  word_t      sum,
  input  word_t      bias,
  input  cfg_t       cfg,
  output logic [7:0] q
);

  word_t x;
  logic signed [63:0] prod;
  logic signed [63:0] prod_rnd;
  logic signed [32:0] y;
  logic signed [33:0] y_ext;
  logic signed [33:0] rnd;
  logic signed [33:0] w;
  logic signed [33:0] z;
  logic [34:0] v;
  logic [7:0] sat;
  logic [7:0] lo;
  logic dec;

  assign prod_rnd = prod + 64'sh4000_0000;
  assign dec = (cfg.shift != '0) && y[32];
  assign y_ext = {y[32], y};
  assign rnd = (cfg.shift != '0) ? (34'sd1 <<< (cfg.shift - 5'd1)) : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      x <= (sum >>> SUM_SHIFT) + bias;
      prod <= x * $signed({1'b0, cfg.multiplier});
      y <= prod_rnd[63:PROD_SHIFT];
      w <= y_ext - $signed({33'b0, dec}) + rnd;
    end
  end

  always_comb begin
    z = w >>> cfg.shift;
    v = {z[33], z} + {27'b0, cfg.zero_point};
    if (v[34]) begin
      sat = 8'd0;
    end else if (v[33:8] != '0) begin
      sat = 8'd255;
    end else begin
      sat = v[7:0];
    end
    lo = (sat < cfg.clamp_low) ? cfg.clamp_low : sat;
    q = (lo > cfg.clamp_high) ? cfg.clamp_high : lo;
  end

endmodule

### hw/rtl/wf23_checker.sv
// Port-level checker for the Winograd F(2,3) output requantizer and its bind.
`timescale 1ns / 1ps

module wf23_checker import wf23_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // A result that waits for the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("out_item changed while stalled");

  // The input side stalls only behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output backpressure");

  // A row that waits for the block keeps its value.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("in_item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind winograd_f23_output_requant_unit wf23_checker u_wf23_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### test/testbench.sv
// Self-checking testbench for the Winograd F(2,3) output requantizer against a tile predictor.
`timescale 1ns / 1ps

module testbench;
  import wf23_pkg::*;

  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 50;
  localparam logic [ADDR_W-1:0] SPARE_ADDR = 5'd24;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  cfg_t        requant_cfg = '{MULT_RESET, SHIFT_RESET, ZP_RESET, LOW_RESET, HIGH_RESET};
  logic [31:0] tile_sums [NUM_LANES] = '{default: '0};
  logic [1:0]  tile_row = '0;
  out_item_t   expected_tiles [$];

  int fail_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int stall_window = 0;
  int burst_left = 0;
  int gap_max = 0;

  winograd_f23_output_requant_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_failure(input string msg);
    if (fail_count < MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic logic [7:0] requant_pixel(input logic [31:0] acc, input word_t bias);
    word_t x;
    longint y;
    longint v;
    x = $signed(acc) >>> SUM_SHIFT;
    x = x + bias;
    y = (longint'(x) * longint'(requant_cfg.multiplier) + (longint'(1) <<< 30)) >>> PROD_SHIFT;
    if (requant_cfg.shift != 0) begin
      if (y < 0) y = y - 1;
      y = (y + (longint'(1) <<< (int'(requant_cfg.shift) - 1))) >>> requant_cfg.shift;
    end
    v = y + longint'(requant_cfg.zero_point);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    if (v < longint'(requant_cfg.clamp_low)) v = longint'(requant_cfg.clamp_low);
    if (v > longint'(requant_cfg.clamp_high)) v = longint'(requant_cfg.clamp_high);
    return v[7:0];
  endfunction

  task automatic accumulate_row(input in_item_t row);
    logic [31:0] a;
    logic [31:0] b;
    out_item_t tile;
    a = row.tile_col0 + row.tile_col1 + row.tile_col2;
    b = row.tile_col1 - row.tile_col2 - row.tile_col3;
    if (tile_row <= 2) begin
      tile_sums[0] = tile_sums[0] + a;
      tile_sums[1] = tile_sums[1] + b;
    end
    if (tile_row == 1) begin
      tile_sums[2] = tile_sums[2] + a;
      tile_sums[3] = tile_sums[3] + b;
    end else if (tile_row >= 2) begin
      tile_sums[2] = tile_sums[2] - a;
      tile_sums[3] = tile_sums[3] - b;
    end
    if (tile_row == LAST_ROW) begin
      tile.out_r0c0 = requant_pixel(tile_sums[0], row.chan_bias);
      tile.out_r0c1 = requant_pixel(tile_sums[1], row.chan_bias);
      tile.out_r1c0 = requant_pixel(tile_sums[2], row.chan_bias);
      tile.out_r1c1 = requant_pixel(tile_sums[3], row.chan_bias);
      expected_tiles.push_back(tile);
      tile_sums = '{default: '0};
    end
    tile_row = tile_row + 2'd1;
  endtask

  // Every accepted row transfer updates the predicted tile state.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) accumulate_row(in_item);
  end

  task automatic check_pixel(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_failure($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tiles.size() == 0) begin
        report_failure("output transfer with no tile pending");
      end else begin
        want = expected_tiles.pop_front();
        check_pixel("out_r0c0", out_item.out_r0c0, want.out_r0c0);
        check_pixel("out_r0c1", out_item.out_r0c1, want.out_r0c1);
        check_pixel("out_r1c0", out_item.out_r1c0, want.out_r1c0);
        check_pixel("out_r1c1", out_item.out_r1c1, want.out_r1c1);
      end
    end
  end

  // The receiver picks a new stall density for each window; a long hold stalls it throughout.
  always @(posedge clk) begin
    if (stall_window == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      stall_window = 64;
    end else begin
      stall_window = stall_window - 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      {REG_MULT, 2'b00}: requant_cfg.multiplier = data[30:0];
      {REG_SHIFT, 2'b00}: requant_cfg.shift = data[4:0];
      {REG_ZP, 2'b00}: requant_cfg.zero_point = data[7:0];
      {REG_LOW, 2'b00}: requant_cfg.clamp_low = data[7:0];
      {REG_HIGH, 2'b00}: requant_cfg.clamp_high = data[7:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_requant(input logic [30:0] mult, input logic [4:0] shift,
                                 input logic [7:0] zp, input logic [7:0] lo,
                                 input logic [7:0] hi);
    apb_write({REG_MULT, 2'b00}, {1'b0, mult});
    apb_write({REG_SHIFT, 2'b00}, {27'd0, shift});
    apb_write({REG_ZP, 2'b00}, {24'd0, zp});
    apb_write({REG_LOW, 2'b00}, {24'd0, lo});
    apb_write({REG_HIGH, 2'b00}, {24'd0, hi});
  endtask

  task automatic offer_row(input in_item_t row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // All four columns of every row carry the same value; the bias on early rows is junk.
  task automatic send_uniform_tile(input word_t value, input word_t bias);
    in_item_t row;
    for (int r = 0; r < 4; r++) begin
      row.tile_col0 = value;
      row.tile_col1 = value;
      row.tile_col2 = value;
      row.tile_col3 = value;
      row.chan_bias = (r == 3) ? bias : ~bias;
      offer_row(row);
    end
  endtask

  function automatic word_t random_word(input int magnitude);
    word_t w;
    w = $urandom;
    case (magnitude)
      0: w = word_t'($urandom_range(0, 8191)) - 32'sd4096;
      1: w = {{8{w[23]}}, w[23:0]};
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_random_tile();
    in_item_t row;
    int pick;
    int magnitude;
    pick = $urandom_range(0, 9);
    magnitude = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
    for (int r = 0; r < 4; r++) begin
      row.tile_col0 = random_word(magnitude);
      row.tile_col1 = random_word(magnitude);
      row.tile_col2 = random_word(magnitude);
      row.tile_col3 = random_word(magnitude);
      if (r != 3) row.chan_bias = $urandom;
      else if ($urandom_range(0, 3) == 0) row.chan_bias = '0;
      else row.chan_bias = random_word($urandom_range(0, 2));
      offer_row(row);
    end
  endtask

  task automatic test_default_extremes();
    gap_max = 3;
    send_uniform_tile(32'sd0, 32'sd100);
    send_uniform_tile(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_uniform_tile(32'sh8000_0000, 32'sh7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    program_requant(31'h7FFF_FFFF, 5'd31, 8'd255, 8'd0, 8'd255);
    send_uniform_tile(-32'sd1, -32'sd7);
    wait_drained();
    program_requant(31'd0, 5'd0, 8'd0, 8'd0, 8'd255);
    send_uniform_tile(32'sd123456, 32'sd5000);
    wait_drained();
    // The lower bound is applied first, so crossed bounds force the upper one.
    program_requant(MULT_RESET, 5'd1, 8'd128, 8'd200, 8'd50);
    apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
    send_uniform_tile(32'sd400, -32'sd300);
    wait_drained();
  endtask

  task automatic program_random_setting();
    logic [7:0] lo;
    logic [7:0] hi;
    logic [4:0] shift;
    lo = 8'($urandom_range(0, 60));
    hi = 8'($urandom_range(180, 255));
    shift = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 8));
    if ($urandom_range(0, 5) == 0) program_requant(31'($urandom), shift, 8'($urandom), hi, lo);
    else program_requant(31'($urandom), shift, 8'($urandom), lo, hi);
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 6; s++) begin
      program_random_setting();
      gap_max = $urandom_range(0, 6);
      repeat (16) send_random_tile();
      wait_drained();
    end
  endtask

  // A long receiver hold fills the block and back-pressures the row input.
  task automatic test_output_hold();
    program_requant(MULT_RESET, 5'd2, 8'd128, 8'd0, 8'd255);
    gap_max = 0;
    hold_left = LONG_HOLD;
    repeat (24) send_random_tile();
    wait_drained();
  endtask

  task automatic test_bursty_source();
    program_random_setting();
    gap_max = 12;
    repeat (9) send_random_tile();
    wait_drained();
    repeat (9) send_random_tile();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_extremes();
    test_register_extremes();
    test_random_settings();
    test_output_hold();
    test_bursty_source();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
